### hw/rtl/m3alu_pkg.sv
// ----------------------------------------------------------------------------
// m3alu_pkg
// Shared types and constants for the 3x3 fixed-point matrix ALU.
// ----------------------------------------------------------------------------
package m3alu_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int ELEM_W_MAX = 16;
    localparam int SCALAR_W   = 16;
    localparam int ROW_W      = 48;
    localparam int DET_W      = 40;
    localparam int DIM        = 3;
    localparam int OPCODE_W   = 3;

    // input beat layout
    localparam int IN_LHS_LSB    = OPCODE_W;
    localparam int IN_RHS_LSB    = IN_LHS_LSB + DIM * ROW_W;
    localparam int IN_SCALAR_LSB = IN_RHS_LSB + DIM * ROW_W;
    localparam int IN_DATA_W     = 312;

    // output beat layout
    localparam int OUT_DET_LSB = DIM * ROW_W;
    localparam int OUT_EQ_BIT  = OUT_DET_LSB + DET_W;
    localparam int OUT_SAT_BIT = OUT_EQ_BIT + 1;
    localparam int OUT_DZ_BIT  = OUT_SAT_BIT + 1;
    localparam int OUT_DATA_W  = 192;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_MUL       = 3'd2,
        OP_SCALE     = 3'd3,
        OP_DIV       = 3'd4,
        OP_TRANSPOSE = 3'd5,
        OP_DET       = 3'd6,
        OP_EQUAL     = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [ELEM_W_MAX-1:0] elem;
        logic                  sat;
        logic                  dz;
        logic                  eq;
    } lane_out_t;

    typedef struct packed {
        logic [DET_W-1:0] value;
        logic             sat;
    } det_out_t;

endpackage

### hw/rtl/m3alu_div.sv
// ----------------------------------------------------------------------------
// m3alu_div
// Pipelined restoring divider: (x * 2^FB) / scalar, truncated toward zero,
// clamped to the element range; one quotient bit per stage.
// ----------------------------------------------------------------------------
module m3alu_div #(
    parameter int ELEM_WIDTH = m3alu_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [ELEM_WIDTH-1:0]          x,
    input  logic signed [m3alu_pkg::SCALAR_W-1:0] sc,
    output logic        [ELEM_WIDTH-1:0]          q_elem,
    output logic                                  q_sat,
    output logic                                  q_dz
);
    localparam int EW = ELEM_WIDTH;
    localparam int SW = m3alu_pkg::SCALAR_W;
    localparam int QW = ELEM_WIDTH + FRAC_BITS;
    localparam logic signed [QW:0] EMAX = {{(QW-EW+2){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [QW:0] EMIN = {{(QW-EW+2){1'b1}}, {(EW-1){1'b0}}};

    logic [SW-1:0] rem_reg [QW+1];
    logic [QW-1:0] nq_reg  [QW+1];
    logic [SW-1:0] d_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          xpos_reg[QW+1];
    logic          xneg_reg[QW+1];
    logic          dz_reg  [QW+1];

    logic [EW-1:0] ax;
    logic [SW-1:0] asc;

    assign ax  = x[EW-1]  ? EW'(-x)  : EW'(x);
    assign asc = sc[SW-1] ? SW'(-sc) : SW'(sc);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            nq_reg[0]   <= QW'(ax) << FRAC_BITS;
            d_reg[0]    <= asc;
            neg_reg[0]  <= x[EW-1] ^ sc[SW-1];
            xpos_reg[0] <= (x > 0);
            xneg_reg[0] <= x[EW-1];
            dz_reg[0]   <= (sc == '0);
        end
    end

    for (genvar i = 1; i <= QW; i++) begin : g_stage
        logic [SW:0]   trial;
        logic          ge;
        logic [SW-1:0] rem_next;
        logic [QW-1:0] nq_next;

        always_comb begin
            trial    = {rem_reg[i-1], nq_reg[i-1][QW-1]};
            ge       = (trial >= {1'b0, d_reg[i-1]});
            rem_next = ge ? SW'(trial - {1'b0, d_reg[i-1]}) : SW'(trial);
            nq_next  = {nq_reg[i-1][QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                nq_reg[i]   <= nq_next;
                d_reg[i]    <= d_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                xpos_reg[i] <= xpos_reg[i-1];
                xneg_reg[i] <= xneg_reg[i-1];
                dz_reg[i]   <= dz_reg[i-1];
            end
        end
    end

    logic signed [QW:0]   qv;
    logic [EW-1:0]        elem_next;
    logic                 sat_next;
    logic [EW-1:0]        elem_reg;
    logic                 sat_reg;
    logic                 dzo_reg;

    always_comb begin
        qv = neg_reg[QW] ? -$signed({1'b0, nq_reg[QW]}) : $signed({1'b0, nq_reg[QW]});
        if (dz_reg[QW]) begin
            // zero divisor: rail by dividend sign
            if (xpos_reg[QW]) begin
                elem_next = EMAX[EW-1:0];
                sat_next  = 1'b1;
            end else if (xneg_reg[QW]) begin
                elem_next = EMIN[EW-1:0];
                sat_next  = 1'b1;
            end else begin
                elem_next = '0;
                sat_next  = 1'b0;
            end
        end else if (qv > EMAX) begin
            elem_next = EMAX[EW-1:0];
            sat_next  = 1'b1;
        end else if (qv < EMIN) begin
            elem_next = EMIN[EW-1:0];
            sat_next  = 1'b1;
        end else begin
            elem_next = qv[EW-1:0];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            elem_reg <= elem_next;
            sat_reg  <= sat_next;
            dzo_reg  <= dz_reg[QW];
        end
    end

    assign q_elem = elem_reg;
    assign q_sat  = sat_reg;
    assign q_dz   = dzo_reg;

endmodule

### hw/rtl/m3alu_lane.sv
// ----------------------------------------------------------------------------
// m3alu_lane
// One result element: add, sub, dot product, scale, transpose, divide and
// element compare, all aligned to the divider latency.
// ----------------------------------------------------------------------------
module m3alu_lane #(
    parameter int ELEM_WIDTH = m3alu_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  m3alu_pkg::opcode_t                    op,
    input  logic signed [ELEM_WIDTH-1:0]          x,
    input  logic signed [ELEM_WIDTH-1:0]          y,
    input  logic signed [ELEM_WIDTH-1:0]          t,
    input  logic signed [ELEM_WIDTH-1:0]          lrow [3],
    input  logic signed [ELEM_WIDTH-1:0]          rcol [3],
    input  logic signed [m3alu_pkg::SCALAR_W-1:0] sc,
    output m3alu_pkg::lane_out_t                  lane_out
);
    localparam int EW    = ELEM_WIDTH;
    localparam int SW    = m3alu_pkg::SCALAR_W;
    localparam int DEPTH = ELEM_WIDTH + FRAC_BITS + 2;
    localparam int ND    = DEPTH - 1;
    localparam int PW    = 2 * EW;
    localparam int VW    = (2 * EW + 2 > EW + SW) ? 2 * EW + 2 : EW + SW + 1;
    localparam logic signed [VW-1:0] EMAX = {{(VW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [VW-1:0] EMIN = {{(VW-EW+1){1'b1}}, {(EW-1){1'b0}}};

    typedef struct packed {
        m3alu_pkg::opcode_t op;
        logic [EW-1:0]      elem;
        logic               sat;
        logic               eq;
    } dl_t;

    // stage 1
    m3alu_pkg::opcode_t    op_reg;
    logic signed [PW-1:0]  p_reg [3];
    logic signed [EW:0]    add_reg;
    logic signed [EW:0]    sub_reg;
    logic signed [EW+SW-1:0] scl_reg;
    logic signed [EW-1:0]  t_reg;
    logic                  eq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg  <= op;
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= PW'(lrow[k]) * PW'(rcol[k]);
            end
            add_reg <= (EW+1)'(x) + (EW+1)'(y);
            sub_reg <= (EW+1)'(x) - (EW+1)'(y);
            scl_reg <= (EW+SW)'(x) * (EW+SW)'(sc);
            t_reg   <= t;
            eq_reg  <= (x == y);
        end
    end

    // stage 2: select, shift, clamp
    logic signed [PW+1:0] mul_sum;
    logic signed [VW-1:0] v;
    dl_t                  st2;

    always_comb begin
        mul_sum = (PW+2)'(p_reg[0]) + (PW+2)'(p_reg[1]) + (PW+2)'(p_reg[2]);
        case (op_reg)
            m3alu_pkg::OP_ADD:       v = VW'(add_reg);
            m3alu_pkg::OP_SUB:       v = VW'(sub_reg);
            m3alu_pkg::OP_MUL:       v = VW'(mul_sum >>> FRAC_BITS);
            m3alu_pkg::OP_SCALE:     v = VW'(scl_reg >>> FRAC_BITS);
            m3alu_pkg::OP_TRANSPOSE: v = VW'(t_reg);
            default:                 v = '0;
        endcase
        st2.op  = op_reg;
        st2.eq  = eq_reg;
        if (v > EMAX) begin
            st2.elem = EMAX[EW-1:0];
            st2.sat  = 1'b1;
        end else if (v < EMIN) begin
            st2.elem = EMIN[EW-1:0];
            st2.sat  = 1'b1;
        end else begin
            st2.elem = v[EW-1:0];
            st2.sat  = 1'b0;
        end
    end

    dl_t dl_reg [ND];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= st2;
            for (int i = 1; i < ND; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    logic [EW-1:0] div_elem;
    logic          div_sat;
    logic          div_dz;

    m3alu_div #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk  (aclk),
        .en    (en),
        .x     (x),
        .sc    (sc),
        .q_elem(div_elem),
        .q_sat (div_sat),
        .q_dz  (div_dz)
    );

    always_comb begin
        lane_out.eq = dl_reg[ND-1].eq;
        if (dl_reg[ND-1].op == m3alu_pkg::OP_DIV) begin
            lane_out.elem = m3alu_pkg::ELEM_W_MAX'(div_elem);
            lane_out.sat  = div_sat;
            lane_out.dz   = div_dz;
        end else begin
            lane_out.elem = m3alu_pkg::ELEM_W_MAX'(dl_reg[ND-1].elem);
            lane_out.sat  = dl_reg[ND-1].sat;
            lane_out.dz   = 1'b0;
        end
    end

endmodule

### hw/rtl/m3alu_det.sv
// ----------------------------------------------------------------------------
// m3alu_det
// Pipelined 3x3 determinant by cofactor expansion along row 0, shifted by
// 2*FB and clamped to 40 bits, delayed to the lane latency.
// ----------------------------------------------------------------------------
module m3alu_det #(
    parameter int ELEM_WIDTH = m3alu_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3alu_pkg::FRAC_BITS_DEF,
    parameter int DEPTH      = ELEM_WIDTH + FRAC_BITS + 2
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [ELEM_WIDTH-1:0] m [3][3],
    output m3alu_pkg::det_out_t          det_out
);
    localparam int EW  = ELEM_WIDTH;
    localparam int PW  = 2 * EW;
    localparam int CW  = 2 * EW + 1;
    localparam int TW  = 3 * EW + 1;
    localparam int DWW = (3 * EW + 3 > m3alu_pkg::DET_W + 1) ? 3 * EW + 3
                                                            : m3alu_pkg::DET_W + 1;
    localparam int ND  = DEPTH - 4;
    localparam logic signed [DWW-1:0] DMAX =
        {{(DWW-m3alu_pkg::DET_W+1){1'b0}}, {(m3alu_pkg::DET_W-1){1'b1}}};
    localparam logic signed [DWW-1:0] DMIN =
        {{(DWW-m3alu_pkg::DET_W+1){1'b1}}, {(m3alu_pkg::DET_W-1){1'b0}}};

    // m[row][col]
    logic signed [EW-1:0] top1_reg [3];
    logic signed [EW-1:0] top2_reg [3];
    logic signed [PW-1:0] pr_reg   [6];
    logic signed [CW-1:0] cf_reg   [3];
    logic signed [TW-1:0] tm_reg   [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                top1_reg[k] <= m[0][k];
                top2_reg[k] <= top1_reg[k];
            end
            pr_reg[0] <= PW'(m[1][1]) * PW'(m[2][2]);
            pr_reg[1] <= PW'(m[1][2]) * PW'(m[2][1]);
            pr_reg[2] <= PW'(m[1][0]) * PW'(m[2][2]);
            pr_reg[3] <= PW'(m[1][2]) * PW'(m[2][0]);
            pr_reg[4] <= PW'(m[1][0]) * PW'(m[2][1]);
            pr_reg[5] <= PW'(m[1][1]) * PW'(m[2][0]);
            for (int k = 0; k < 3; k++) begin
                cf_reg[k] <= CW'(pr_reg[2*k]) - CW'(pr_reg[2*k+1]);
                tm_reg[k] <= TW'(top2_reg[k]) * TW'(cf_reg[k]);
            end
        end
    end

    logic signed [DWW-1:0] dsum;
    logic signed [DWW-1:0] dsh;
    m3alu_pkg::det_out_t   st4;

    always_comb begin
        dsum = DWW'(tm_reg[0]) - DWW'(tm_reg[1]) + DWW'(tm_reg[2]);
        dsh  = dsum >>> (2 * FRAC_BITS);
        if (dsh > DMAX) begin
            st4.value = DMAX[m3alu_pkg::DET_W-1:0];
            st4.sat   = 1'b1;
        end else if (dsh < DMIN) begin
            st4.value = DMIN[m3alu_pkg::DET_W-1:0];
            st4.sat   = 1'b1;
        end else begin
            st4.value = dsh[m3alu_pkg::DET_W-1:0];
            st4.sat   = 1'b0;
        end
    end

    m3alu_pkg::det_out_t st4_reg;
    m3alu_pkg::det_out_t dl_reg [ND];

    always_ff @(posedge aclk) begin
        if (en) begin
            st4_reg   <= st4;
            dl_reg[0] <= st4_reg;
            for (int i = 1; i < ND; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    assign det_out = dl_reg[ND-1];

endmodule

### hw/rtl/mat3_fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// mat3_fixed_point_alu_unit
// 3x3 signed fixed-point matrix ALU: nine element lanes, a determinant
// pipeline and a merge stage that packs the result beat.
// ----------------------------------------------------------------------------
// Usage:
//   One beat on s_axis carries opcode, two matrices and a scalar; exactly one
//   beat leaves on m_axis for each one taken, in order.
//   Throughput: one beat per cycle, sustained while m_tready is high.
//   Pipeline depth, from input accept to m_tvalid, is set by the divider in
//   each lane, which resolves one quotient bit per pipeline stage; every
//   other path is delayed to match it, plus one merge/output register.
//   Back-pressure: the pipeline advances whenever the output register is
//   empty or is being drained; while m_tvalid is high and m_tready low the
//   whole pipe holds and s_tready is low.
//   Reset (aresetn low, synchronous): all valid bits and the output valid
//   clear; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module mat3_fixed_point_alu_unit #(
    parameter int ELEM_WIDTH = m3alu_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // opcode[2:0], lhs_row0..2, rhs_row0..2 (48 each), scalar[16], zero pad
    input  logic [m3alu_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // res_row0..2 (48 each), det_value[40], equal_flag, saturated,
    // div_by_zero, zero pad
    output logic [m3alu_pkg::OUT_DATA_W-1:0]     m_tdata
);
    localparam int EW    = ELEM_WIDTH;
    localparam int DEPTH = ELEM_WIDTH + FRAC_BITS + 2;
    localparam int RW    = m3alu_pkg::ROW_W;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // unpack beat: element [row][col]
    m3alu_pkg::opcode_t                    op_in;
    logic signed [EW-1:0]                  l_el [3][3];
    logic signed [EW-1:0]                  r_el [3][3];
    logic signed [m3alu_pkg::SCALAR_W-1:0] sc_in;

    always_comb begin
        op_in = m3alu_pkg::opcode_t'(s_tdata[m3alu_pkg::OPCODE_W-1:0]);
        sc_in = s_tdata[m3alu_pkg::IN_SCALAR_LSB +: m3alu_pkg::SCALAR_W];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                l_el[r][c] = s_tdata[m3alu_pkg::IN_LHS_LSB + r*RW + c*EW +: EW];
                r_el[r][c] = s_tdata[m3alu_pkg::IN_RHS_LSB + r*RW + c*EW +: EW];
            end
        end
    end

    m3alu_pkg::lane_out_t lane_out [3][3];

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            logic signed [EW-1:0] lrow [3];
            logic signed [EW-1:0] rcol [3];
            always_comb begin
                for (int k = 0; k < 3; k++) begin
                    lrow[k] = l_el[r][k];
                    rcol[k] = r_el[k][c];
                end
            end
            m3alu_lane #(
                .ELEM_WIDTH(ELEM_WIDTH),
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk    (aclk),
                .en      (en),
                .op      (op_in),
                .x       (l_el[r][c]),
                .y       (r_el[r][c]),
                .t       (l_el[c][r]),
                .lrow    (lrow),
                .rcol    (rcol),
                .sc      (sc_in),
                .lane_out(lane_out[r][c])
            );
        end
    end

    m3alu_pkg::det_out_t det_out;

    m3alu_det #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .DEPTH     (DEPTH)
    ) u_det (
        .aclk   (aclk),
        .en     (en),
        .m      (l_el),
        .det_out(det_out)
    );

    // valid and opcode track the lanes
    logic               vld_reg [DEPTH];
    m3alu_pkg::opcode_t op_reg  [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg[0] <= op_in;
            for (int i = 1; i < DEPTH; i++) begin
                op_reg[i] <= op_reg[i-1];
            end
        end
    end

    // merge
    logic [m3alu_pkg::OUT_DATA_W-1:0] data_next;
    logic                             sat_any;
    logic                             eq_all;
    logic                             is_det;

    always_comb begin
        data_next = '0;
        sat_any   = 1'b0;
        eq_all    = 1'b1;
        is_det    = (op_reg[DEPTH-1] == m3alu_pkg::OP_DET);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                data_next[r*RW + c*EW +: EW] = lane_out[r][c].elem[EW-1:0];
                sat_any = sat_any | lane_out[r][c].sat;
                eq_all  = eq_all & lane_out[r][c].eq;
            end
        end
        if (is_det) begin
            data_next[m3alu_pkg::OUT_DET_LSB +: m3alu_pkg::DET_W] = det_out.value;
            sat_any = sat_any | det_out.sat;
        end
        data_next[m3alu_pkg::OUT_EQ_BIT]  = eq_all &&
                                            (op_reg[DEPTH-1] == m3alu_pkg::OP_EQUAL);
        data_next[m3alu_pkg::OUT_SAT_BIT] = sat_any;
        data_next[m3alu_pkg::OUT_DZ_BIT]  = lane_out[0][0].dz;
    end

    logic                             m_tvalid_reg;
    logic [m3alu_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/mat3_fixed_point_alu_unit_test.sv
// ----------------------------------------------------------------------------
// mat3_fixed_point_alu_unit_test
// Self-checking bench for the 3x3 fixed-point matrix ALU: a directed table
// of corner cases, then random beats, each result beat checked field by field
// against a table entry or an in-bench prediction, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module mat3_fixed_point_alu_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = 16;
    localparam int FB = 8;
    localparam longint EMAX = 32767;
    localparam longint EMIN = -32768;
    localparam longint DMAX = 64'sd549755813887;
    localparam longint DMIN = -64'sd549755813888;

    // fields from the top bit down; res_row0 ends up in the lowest bits
    typedef struct packed {
        logic        dz, sat, eq;
        logic [39:0] det;
        logic [47:0] r2, r1, r0;
    } mres_t;

    typedef struct {
        m3alu_pkg::opcode_t op;
        logic [47:0]        l[3];
        logic [47:0]        r[3];
        logic [15:0]        sc;
        bit                 known;
        mres_t              want;
    } vec_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [m3alu_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [m3alu_pkg::OUT_DATA_W-1:0] m_tdata;

    mres_t pending[$];
    int    errors = 0;
    bit    hold_off = 0;
    bit    sending = 1;

    always #5 aclk = ~aclk;

    mat3_fixed_point_alu_unit uut (.*);

    function automatic longint el(logic [47:0] row, int c);
        return longint'($signed(row[c*EW +: EW]));
    endfunction

    function automatic logic [15:0] clampe(longint v, inout bit sat);
        if (v > EMAX) begin v = EMAX; sat = 1; end
        if (v < EMIN) begin v = EMIN; sat = 1; end
        return v[15:0];
    endfunction

    function automatic mres_t alu_predict(vec_t t);
        mres_t o;
        logic [47:0] rr[3];
        longint x, v, s, dt;
        longint m[3][3];
        bit sat, dz, eq;
        o = '0; sat = 0; dz = 0; eq = 1;
        s = longint'($signed(t.sc));
        for (int j = 0; j < 3; j++) begin
            rr[j] = '0;
            for (int i = 0; i < 3; i++) m[j][i] = el(t.l[j], i);
        end
        if (t.op == m3alu_pkg::OP_DET) begin
            dt = m[0][0] * (m[1][1]*m[2][2] - m[1][2]*m[2][1])
               - m[0][1] * (m[1][0]*m[2][2] - m[1][2]*m[2][0])
               + m[0][2] * (m[1][0]*m[2][1] - m[1][1]*m[2][0]);
            dt = dt >>> (2*FB);
            if (dt > DMAX) begin dt = DMAX; sat = 1; end
            if (dt < DMIN) begin dt = DMIN; sat = 1; end
            o.det = dt[39:0];
        end else if (t.op == m3alu_pkg::OP_EQUAL) begin
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++)
                    if (m[j][i] != el(t.r[j], i)) eq = 0;
            o.eq = eq;
        end else begin
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++) begin
                    x = m[j][i];
                    v = 0;
                    case (t.op)
                        m3alu_pkg::OP_ADD: v = x + el(t.r[j], i);
                        m3alu_pkg::OP_SUB: v = x - el(t.r[j], i);
                        m3alu_pkg::OP_MUL: begin
                            for (int k = 0; k < 3; k++) v += m[j][k] * el(t.r[k], i);
                            v = v >>> FB;
                        end
                        m3alu_pkg::OP_SCALE: v = (x * s) >>> FB;
                        m3alu_pkg::OP_DIV: begin
                            if (s == 0) begin
                                dz = 1;
                                if (x > 0) begin v = EMAX; sat = 1; end
                                else if (x < 0) begin v = EMIN; sat = 1; end
                            end else v = (x * (64'sd1 << FB)) / s;
                        end
                        default: v = m[i][j];
                    endcase
                    rr[j][i*EW +: EW] = clampe(v, sat);
                end
            o.r0 = rr[0]; o.r1 = rr[1]; o.r2 = rr[2];
            o.dz = dz;
        end
        o.sat = sat;
        return o;
    endfunction

    function automatic logic [47:0] pack3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        return {c, b, a};
    endfunction

    function automatic logic [15:0] rnd_elem();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rnd_row();
        return pack3(rnd_elem(), rnd_elem(), rnd_elem());
    endfunction

    // drives one beat and waits for its acceptance; tvalid drops only for a gap
    task automatic send_beat(vec_t t);
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {t.sc, t.r[2], t.r[1], t.r[0], t.l[2], t.l[1], t.l[0], t.op};
        s_tvalid <= 1;
        pending.push_back(t.known ? t.want : alu_predict(t));
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic vec_t mk(m3alu_pkg::opcode_t op, logic [47:0] lr, logic [47:0] rr,
                                logic [15:0] sc);
        vec_t t;
        t.op = op; t.sc = sc; t.known = 0; t.want = '0;
        for (int j = 0; j < 3; j++) begin t.l[j] = lr; t.r[j] = rr; end
        return t;
    endfunction

    // result side: random stalls plus a long hold-off on request
    initial begin
        mres_t got, w;
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(mres_t)-1:0];
                if (m_tdata[m3alu_pkg::OUT_DATA_W-1:$bits(mres_t)] != '0) begin
                    $error("pad expected 0 actual %h",
                           m_tdata[m3alu_pkg::OUT_DATA_W-1:$bits(mres_t)]);
                    errors++;
                end
                if (pending.size() == 0) begin
                    $error("unexpected result beat %h", got);
                    errors++;
                end else begin
                    w = pending.pop_front();
                    if (got.r0 !== w.r0) begin
                        $error("res_row0 expected %h actual %h", w.r0, got.r0); errors++; end
                    if (got.r1 !== w.r1) begin
                        $error("res_row1 expected %h actual %h", w.r1, got.r1); errors++; end
                    if (got.r2 !== w.r2) begin
                        $error("res_row2 expected %h actual %h", w.r2, got.r2); errors++; end
                    if (got.det !== w.det) begin
                        $error("det_value expected %h actual %h", w.det, got.det); errors++; end
                    if (got.eq !== w.eq) begin
                        $error("equal_flag expected %b actual %b", w.eq, got.eq); errors++; end
                    if (got.sat !== w.sat) begin
                        $error("saturated expected %b actual %b", w.sat, got.sat); errors++; end
                    if (got.dz !== w.dz) begin
                        $error("div_by_zero expected %b actual %b", w.dz, got.dz); errors++; end
                end
            end
            if (hold_off) begin
                m_tready <= 0;
                repeat (200) @(posedge aclk);
                hold_off = 0;
                m_tready <= 1;
            end else begin
                gap = $urandom_range(0, 9);
                if (gap == 0 && $urandom_range(0, 9) == 0) begin
                    m_tready <= 0;
                    repeat ($urandom_range(10, 60)) @(posedge aclk);
                    m_tready <= 1;
                end else begin
                    m_tready <= (gap > 2) || !sending;
                end
            end
        end
    end

    initial begin
        vec_t tbl[$];
        vec_t t;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: all-zero add, zero divided by zero, equality, extremes
        t = mk(m3alu_pkg::OP_ADD, '0, '0, '0); t.known = 1; tbl.push_back(t);
        t = mk(m3alu_pkg::OP_DIV, '0, '0, '0); t.known = 1; t.want.dz = 1; tbl.push_back(t);
        t = mk(m3alu_pkg::OP_EQUAL, 48'h123456789abc, 48'h123456789abc, '0);
        t.known = 1; t.want.eq = 1; tbl.push_back(t);
        t = mk(m3alu_pkg::OP_DET, '0, '1, 16'hffff); t.known = 1; tbl.push_back(t);
        t = mk(m3alu_pkg::OP_ADD, {3{16'h7fff}}, {3{16'h7fff}}, '0); t.known = 1;
        t.want.r0 = {3{16'h7fff}}; t.want.r1 = t.want.r0; t.want.r2 = t.want.r0;
        t.want.sat = 1; tbl.push_back(t);
        t = mk(m3alu_pkg::OP_SUB, {3{16'h8000}}, {3{16'h7fff}}, '0); t.known = 1;
        t.want.r0 = {3{16'h8000}}; t.want.r1 = t.want.r0; t.want.r2 = t.want.r0;
        t.want.sat = 1; tbl.push_back(t);
        tbl.push_back(mk(m3alu_pkg::OP_DIV, pack3(16'h7fff, 16'h8000, 16'h0), '0, '0));
        tbl.push_back(mk(m3alu_pkg::OP_DIV, {3{16'h8000}}, '0, 16'hffff));
        tbl.push_back(mk(m3alu_pkg::OP_DIV, pack3(16'h0100, 16'hff00, 16'h7fff), '0,
                         16'h0003));
        tbl.push_back(mk(m3alu_pkg::OP_DIV, pack3(16'hfffd, 16'h0005, 16'h8000), '0,
                         16'h8000));
        tbl.push_back(mk(m3alu_pkg::OP_SCALE, {3{16'h8000}}, '0, 16'h8000));
        tbl.push_back(mk(m3alu_pkg::OP_SCALE, pack3(16'hffff, 16'h7fff, 16'h0101), '0,
                         16'h7fff));
        tbl.push_back(mk(m3alu_pkg::OP_MUL, {3{16'h8000}}, {3{16'h8000}}, '0));
        tbl.push_back(mk(m3alu_pkg::OP_MUL, pack3(16'hffff, 16'h0001, 16'h0100),
                         {3{16'h0180}}, '0));
        tbl.push_back(mk(m3alu_pkg::OP_DET, {3{16'h8000}}, '0, '0));
        tbl.push_back(mk(m3alu_pkg::OP_EQUAL, '1, 48'hffffffff7fff, '0));
        for (int n = 0; n < 6; n++) begin
            t = mk(m3alu_pkg::opcode_t'(n == 5 ? m3alu_pkg::OP_DET : n + 2), '0, '0,
                   16'($urandom));
            for (int j = 0; j < 3; j++) begin t.l[j] = rnd_row(); t.r[j] = rnd_row(); end
            if (n == 5)
                t.l[0] = pack3(16'h8000, 16'h7fff, 16'h8000);
            tbl.push_back(t);
        end
        t = mk(m3alu_pkg::OP_TRANSPOSE, '0, '1, '1);
        t.l[0] = 48'h000300020001; t.l[1] = 48'h000600050004; t.l[2] = 48'h000900080007;
        tbl.push_back(t);
        foreach (tbl[i]) send_beat(tbl[i]);

        for (int n = 0; n < 1700; n++) begin
            t.op = m3alu_pkg::opcode_t'($urandom_range(0, 7));
            t.known = 0;
            t.sc = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
            for (int j = 0; j < 3; j++) begin t.l[j] = rnd_row(); t.r[j] = rnd_row(); end
            if (t.op == m3alu_pkg::OP_EQUAL && $urandom_range(0, 1))
                for (int j = 0; j < 3; j++) t.r[j] = t.l[j];
            if (n == 400) hold_off = 1;
            if (n == 900) begin
                s_tvalid <= 0;
                wait (pending.size() == 0);
            end
            send_beat(t);
        end
        s_tvalid <= 0;
        sending = 0;
        wait (pending.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end
endmodule
